@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL of the voice stream block, included by the frame core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// An expression that must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  `ASSERT_CLK(lbl, clk, rst, !(expr), msg)

`endif

@@ rtl/vgvs_pkg.sv @@
// Package of the voice stream block: widths, register indexes, reset values and beat types.
package vgvs_pkg;

  localparam int FRAME_SAMPLES = 160;
  localparam int IDX_W = (FRAME_SAMPLES > 1) ? $clog2(FRAME_SAMPLES) : 1;

  localparam int SAMPLE_W = 16;
  localparam int PCT_W = 7;
  localparam int THR_W = 15;
  localparam int RUN_W = 10;
  localparam int ENERGY_W = 40;
  localparam int THR_SQ_W = 2 * THR_W;
  localparam int LIM_W = THR_SQ_W + $clog2(FRAME_SAMPLES + 1);

  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = THR_W;

  typedef logic [CFG_IDX_W-1:0] cfg_index_t;
  localparam cfg_index_t CFG_PUSH_TO_TALK_MODE = cfg_index_t'(0);
  localparam cfg_index_t CFG_WAKE_THRESHOLD_PCT = cfg_index_t'(1);
  localparam cfg_index_t CFG_ENERGY_THRESHOLD = cfg_index_t'(2);
  localparam cfg_index_t CFG_SILENCE_FRAME_LIMIT = cfg_index_t'(3);

  localparam logic [PCT_W-1:0] RST_WAKE_THRESHOLD = PCT_W'(50);
  localparam logic [THR_W-1:0] RST_ENERGY_THRESHOLD = THR_W'(300);
  localparam logic [RUN_W-1:0] RST_SILENCE_LIMIT = RUN_W'(80);
  localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [PCT_W-1:0] wake_confidence_pct;
    logic muted;
    logic paused;
    logic ptt_pressed;
  } item_t;

  typedef struct packed {
    logic forward_valid;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic stream_end;
    logic streaming;
    logic frame_last;
  } result_t;

  // Settings handed from the register bank to the frame core.
  typedef struct packed {
    logic ptt_mode;
    logic [PCT_W-1:0] wake_threshold;
    logic [RUN_W-1:0] silence_limit;
    logic [LIM_W-1:0] energy_limit;
  } cfg_t;

endpackage

@@ rtl/vgvs_frame_core.sv @@
// Frame state and per-sample decision logic of the voice stream block.
`include "assert_macros.svh"

module vgvs_frame_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  vgvs_pkg::item_t   item,
  input  vgvs_pkg::cfg_t    cfg,
  output vgvs_pkg::result_t result
);

  logic                            stream_state, stream_state_next;
  logic [vgvs_pkg::RUN_W-1:0]      silent_run, silent_run_next;
  logic [vgvs_pkg::IDX_W-1:0]      sample_index, sample_index_next;
  logic [vgvs_pkg::ENERGY_W-1:0]   energy_sum, energy_sum_next;
  logic                            prev_button, prev_button_next;
  logic                            flag_muted, flag_paused, flag_ptt;
  logic                            flag_muted_next, flag_paused_next, flag_ptt_next;
  logic                            frame_forward, frame_forward_next;

  logic                            first, last, ended;
  logic [vgvs_pkg::SAMPLE_W-1:0]   mag;
  logic [2*vgvs_pkg::SAMPLE_W-1:0] sq;
  logic [vgvs_pkg::RUN_W-1:0]      run_inc;
  logic                            silent;

  assign first = (sample_index == '0);
  assign last  = ({1'b0, sample_index} >= (vgvs_pkg::IDX_W + 1)'(vgvs_pkg::FRAME_SAMPLES - 1));

  // Magnitude as unsigned, so the most negative sample squares correctly.
  assign mag = item.sample[vgvs_pkg::SAMPLE_W-1] ? (~item.sample + 1'b1) : item.sample;
  assign sq  = mag * mag;

  assign energy_sum_next = (first ? '0 : energy_sum) + vgvs_pkg::ENERGY_W'(sq);
  assign silent = energy_sum_next < vgvs_pkg::ENERGY_W'(cfg.energy_limit);
  assign run_inc = (silent_run < vgvs_pkg::RUN_MAX) ? silent_run + 1'b1 : silent_run;

  always_comb begin
    stream_state_next = stream_state;
    silent_run_next   = silent_run;
    prev_button_next  = prev_button;
    flag_muted_next   = flag_muted;
    flag_paused_next  = flag_paused;
    flag_ptt_next     = flag_ptt;
    frame_forward_next = frame_forward;
    ended = 1'b0;

    if (first) begin
      flag_muted_next    = item.muted;
      flag_paused_next   = item.paused;
      flag_ptt_next      = item.ptt_pressed;
      frame_forward_next = 1'b0;
      if (item.muted) begin
        stream_state_next = 1'b0;
        prev_button_next  = 1'b0;
      end else if (!item.paused) begin
        if (cfg.ptt_mode) begin
          if (!prev_button && item.ptt_pressed) begin
            stream_state_next = 1'b1;
          end
          frame_forward_next = (stream_state || (!prev_button && item.ptt_pressed))
                               && item.ptt_pressed;
        end else begin
          frame_forward_next = stream_state;
        end
      end
    end

    if (last && !flag_muted_next && !flag_paused_next) begin
      if (cfg.ptt_mode) begin
        if (prev_button_next && !flag_ptt_next && stream_state_next) begin
          stream_state_next = 1'b0;
          ended = 1'b1;
        end
        prev_button_next = flag_ptt_next;
      end else if (!stream_state_next) begin
        if (item.wake_confidence_pct >= cfg.wake_threshold) begin
          stream_state_next = 1'b1;
          silent_run_next   = '0;
        end
      end else if (silent) begin
        silent_run_next = run_inc;
        if (run_inc >= cfg.silence_limit) begin
          silent_run_next   = '0;
          stream_state_next = 1'b0;
          ended = 1'b1;
        end
      end else begin
        silent_run_next = '0;
      end
    end

    sample_index_next = last ? '0 : sample_index + 1'b1;
  end

  assign result.forward_valid = frame_forward_next;
  assign result.sample_out    = item.sample;
  assign result.stream_end    = ended;
  assign result.streaming     = stream_state_next;
  assign result.frame_last    = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      stream_state  <= 1'b0;
      silent_run    <= '0;
      sample_index  <= '0;
      energy_sum    <= '0;
      prev_button   <= 1'b0;
      flag_muted    <= 1'b0;
      flag_paused   <= 1'b0;
      flag_ptt      <= 1'b0;
      frame_forward <= 1'b0;
    end else if (step) begin
      stream_state  <= stream_state_next;
      silent_run    <= silent_run_next;
      sample_index  <= sample_index_next;
      energy_sum    <= energy_sum_next;
      prev_button   <= prev_button_next;
      flag_muted    <= flag_muted_next;
      flag_paused   <= flag_paused_next;
      flag_ptt      <= flag_ptt_next;
      frame_forward <= frame_forward_next;
    end
  end

  `ASSERT_CLK(a_wrap_after_last, clk, rst, step && last |=> sample_index == '0,
              "sample index did not wrap after the closing sample of a frame")
  `ASSERT_CLK(a_index_steps, clk, rst,
              step && !last |=> sample_index == $past(sample_index) + 1'b1,
              "sample index did not advance by one")
  `ASSERT_CLK(a_end_goes_idle, clk, rst, step && ended |=> !stream_state,
              "stream end was flagged but the block kept streaming")

endmodule

@@ rtl/vad_gated_voice_stream.sv @@
// Top level of the energy-gated voice stream block: handshakes, registers, pipeline.
//
// Mono samples enter one beat at a time and are grouped into frames of
// vgvs_pkg::FRAME_SAMPLES samples; every input beat yields exactly one result
// beat carrying the sample, whether it is to be forwarded, the streaming state,
// a frame-closing mark and a stream-end mark. The block sustains one sample per
// clock while the output is not stalled: a beat is taken into an input register,
// its decision is made there by the frame core, and the result sits in an output
// register until the consumer takes it, so a stalled output holds at most one
// further beat in the input register. The per-cycle path is one 16 by 16 squarer
// feeding the 40-bit energy accumulator and its compare against the energy limit.
// Configuration is written over its own channel, which is always ready; the
// energy threshold is squared into a register on write and then scaled by the
// frame length into the energy limit register, from which it takes effect.
// Writes to indexes beyond the four registers are accepted and ignored.

module vad_gated_voice_stream (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  vgvs_pkg::item_t                item,
  output logic                          result_valid,
  input  logic                          result_ready,
  output vgvs_pkg::result_t              result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  vgvs_pkg::cfg_index_t           cfg_index,
  input  logic [vgvs_pkg::CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers. The energy threshold is kept only as its square
  // and as the full energy limit, threshold squared times frame length.
  logic                            ptt_mode;
  logic [vgvs_pkg::PCT_W-1:0]      wake_threshold;
  logic [vgvs_pkg::RUN_W-1:0]      silence_limit;
  logic [vgvs_pkg::THR_SQ_W-1:0]   thr_sq;
  logic [vgvs_pkg::LIM_W-1:0]      energy_limit;
  logic [vgvs_pkg::THR_SQ_W-1:0]   thr_sq_write;
  logic                            cfg_write;

  // Input pipeline register, its handshake and the signals around the frame core.
  logic                            s1_valid;
  vgvs_pkg::item_t                  s1_item;
  logic                            advance;
  vgvs_pkg::cfg_t                   core_cfg;
  vgvs_pkg::result_t                core_result;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign thr_sq_write = vgvs_pkg::THR_SQ_W'(cfg_data) * vgvs_pkg::THR_SQ_W'(cfg_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      ptt_mode       <= 1'b0;
      wake_threshold <= vgvs_pkg::RST_WAKE_THRESHOLD;
      silence_limit  <= vgvs_pkg::RST_SILENCE_LIMIT;
      thr_sq         <= vgvs_pkg::THR_SQ_W'(vgvs_pkg::RST_ENERGY_THRESHOLD)
                        * vgvs_pkg::THR_SQ_W'(vgvs_pkg::RST_ENERGY_THRESHOLD);
      energy_limit   <= vgvs_pkg::LIM_W'(vgvs_pkg::RST_ENERGY_THRESHOLD)
                        * vgvs_pkg::LIM_W'(vgvs_pkg::RST_ENERGY_THRESHOLD)
                        * vgvs_pkg::LIM_W'(vgvs_pkg::FRAME_SAMPLES);
    end else begin
      // The limit follows the squared threshold, taking its new value in the cycle after it changes.
      energy_limit <= vgvs_pkg::LIM_W'(thr_sq) * vgvs_pkg::LIM_W'(vgvs_pkg::FRAME_SAMPLES);
      if (cfg_write) begin
        unique case (cfg_index)
          vgvs_pkg::CFG_PUSH_TO_TALK_MODE:   ptt_mode       <= cfg_data[0];
          vgvs_pkg::CFG_WAKE_THRESHOLD_PCT:  wake_threshold <= cfg_data[vgvs_pkg::PCT_W-1:0];
          vgvs_pkg::CFG_ENERGY_THRESHOLD:    thr_sq         <= thr_sq_write;
          vgvs_pkg::CFG_SILENCE_FRAME_LIMIT: silence_limit  <= cfg_data[vgvs_pkg::RUN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign core_cfg.ptt_mode       = ptt_mode;
  assign core_cfg.wake_threshold = wake_threshold;
  assign core_cfg.silence_limit  = silence_limit;
  assign core_cfg.energy_limit   = energy_limit;

  // A held beat moves on whenever the output register is empty or being read.
  assign advance    = s1_valid && (!result_valid || result_ready);
  assign item_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (item_valid && item_ready) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      s1_item <= item;
    end
    if (advance) begin
      result <= core_result;
    end
  end

  vgvs_frame_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (s1_item),
    .cfg    (core_cfg),
    .result (core_result)
  );

endmodule
